// ----- src/fchd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchd_pkg
// Shared types and constants for the fan curve duty core.
// ----------------------------------------------------------------------------
package fchd_pkg;

  localparam int TEMP_W       = 18;  // millidegree sample width
  localparam int DEG_W        = 8;   // saturated whole degrees
  localparam int SPEED_W      = 7;   // clamped speed percent, 0..100
  localparam int LEVEL_W      = 4;   // curve point plus one
  localparam int DUTY_W       = 32;
  localparam int PERIOD_W     = 32;
  localparam int PERIOD_DIV_W = 26;  // floor(2^32-1 / 100) fits here
  localparam int CURVE_W      = 64;  // eight packed bytes
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;

  // x / 1000 = (x * DEG_MUL) >> DEG_SHIFT, exact for x < 2^18
  localparam logic [TEMP_W-1:0] DEG_MUL   = 18'd134218;
  localparam int                DEG_SHIFT = 27;

  // x / 100 = (x * PCT_MUL) >> PCT_SHIFT, exact for 32-bit x
  localparam logic [PERIOD_W-1:0] PCT_MUL   = 32'd2748779070;
  localparam int                  PCT_SHIFT = 38;

  localparam logic [SPEED_W-1:0] MAX_SPEED = 7'd100;

  typedef logic signed [TEMP_W-1:0]  temp_t;
  typedef logic signed [DEG_W-1:0]   deg_t;
  typedef logic [SPEED_W-1:0]        speed_t;
  typedef logic [LEVEL_W-1:0]        level_t;
  typedef logic [DUTY_W-1:0]         duty_t;
  typedef logic [PERIOD_W-1:0]       period_t;
  typedef logic [PERIOD_DIV_W-1:0]   period_div_t;
  typedef logic [CURVE_W-1:0]        curve_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ON_THRESHOLDS  = 2'd0,
    REG_OFF_THRESHOLDS = 2'd1,
    REG_SPEED_TABLE    = 2'd2,
    REG_PWM_PERIOD     = 2'd3
  } reg_index_t;

endpackage

// ----- src/fchd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchd_if
// Valid/ready channels: temperature requests in, duty results out.
// ----------------------------------------------------------------------------
interface fchd_temp_if;
  logic            valid;
  logic            ready;
  fchd_pkg::temp_t temp_milli;

  modport source (output valid, output temp_milli, input ready);
  modport sink   (input valid, input temp_milli, output ready);
endinterface

interface fchd_duty_if;
  logic             valid;
  logic             ready;
  fchd_pkg::duty_t  duty;
  fchd_pkg::level_t level;

  modport source (output valid, output duty, output level, input ready);
  modport sink   (input valid, input duty, input level, output ready);
endinterface

// ----- src/fchd_temp_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchd_temp_scale
// Millidegrees to saturated whole degrees, truncating toward zero.
// ----------------------------------------------------------------------------
module fchd_temp_scale (
  input  logic            clk,
  input  logic            load,
  input  fchd_pkg::temp_t temp_milli,
  output fchd_pkg::deg_t  deg
);

  logic                               neg;
  logic [fchd_pkg::TEMP_W-1:0]        mag;
  logic [2*fchd_pkg::TEMP_W-1:0]      prod;
  logic [2*fchd_pkg::TEMP_W-fchd_pkg::DEG_SHIFT-1:0] quot;
  fchd_pkg::deg_t                     deg_next;

  always_comb begin
    neg  = temp_milli[fchd_pkg::TEMP_W-1];
    // magnitude of the most negative code still fits unsigned
    mag  = neg ? fchd_pkg::TEMP_W'(-temp_milli) : fchd_pkg::TEMP_W'(temp_milli);
    prod = (2*fchd_pkg::TEMP_W)'(mag) * (2*fchd_pkg::TEMP_W)'(fchd_pkg::DEG_MUL);
    quot = prod[2*fchd_pkg::TEMP_W-1:fchd_pkg::DEG_SHIFT];
    if (neg) begin
      if (quot >= 9'd128) begin
        deg_next = 8'h80;
      end else begin
        deg_next = 8'(-quot);
      end
    end else begin
      if (quot > 9'd127) begin
        deg_next = 8'h7f;
      end else begin
        deg_next = 8'(quot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      deg <= deg_next;
    end
  end

endmodule

// ----- src/fchd_curve.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchd_curve
// Hysteresis compare per curve point, priority pick of the speed.
// ----------------------------------------------------------------------------
module fchd_curve #(
  parameter int POINTS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fchd_pkg::deg_t   deg,
  input  fchd_pkg::curve_t on_thresholds,
  input  fchd_pkg::curve_t off_thresholds,
  input  fchd_pkg::curve_t speed_table,
  output fchd_pkg::speed_t speed,
  output fchd_pkg::level_t level
);

  logic [POINTS-1:0] active;
  logic [POINTS-1:0] active_next;
  fchd_pkg::level_t  level_next;
  logic [7:0]        speed_raw;
  fchd_pkg::speed_t  speed_next;

  always_comb begin
    active_next = '0;
    level_next  = '0;
    speed_raw   = '0;
    for (int p = 0; p < POINTS; p++) begin
      if ((deg >= $signed(on_thresholds[8*p +: 8])) ||
          ((deg >= $signed(off_thresholds[8*p +: 8])) && active[p])) begin
        active_next[p] = 1'b1;
        level_next     = fchd_pkg::LEVEL_W'(p + 1);
        speed_raw      = speed_table[8*p +: 8];
      end
    end
    if (speed_raw > 8'(fchd_pkg::MAX_SPEED)) begin
      speed_next = fchd_pkg::MAX_SPEED;
    end else begin
      speed_next = fchd_pkg::SPEED_W'(speed_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (load) begin
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      speed <= speed_next;
      level <= level_next;
    end
  end

endmodule

// ----- src/fchd_duty.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchd_duty
// Period over 100, then speed percent times that quotient.
// ----------------------------------------------------------------------------
module fchd_duty (
  input  logic              clk,
  input  logic              load,
  input  fchd_pkg::period_t pwm_period,
  input  fchd_pkg::speed_t  speed,
  input  fchd_pkg::level_t  level_in,
  output fchd_pkg::duty_t   duty,
  output fchd_pkg::level_t  level
);

  localparam int PROD_W = 2 * fchd_pkg::PERIOD_W;
  localparam int MUL_W  = fchd_pkg::SPEED_W + fchd_pkg::PERIOD_DIV_W;

  logic [PROD_W-1:0]     period_prod;
  fchd_pkg::period_div_t period_div;
  logic [MUL_W-1:0]      duty_prod;

  // quotient is registered, tracking the period register from the next cycle
  assign period_prod = PROD_W'(pwm_period) * PROD_W'(fchd_pkg::PCT_MUL);
  assign duty_prod   = MUL_W'(speed) * MUL_W'(period_div);

  always_ff @(posedge clk) begin
    period_div <= period_prod[fchd_pkg::PCT_SHIFT +: fchd_pkg::PERIOD_DIV_W];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty  <= duty_prod[fchd_pkg::DUTY_W-1:0];
      level <= level_in;
    end
  end

endmodule

// ----- src/fan_curve_hysteresis_duty_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_curve_hysteresis_duty_core
// Fan PWM duty from temperature samples, using a curve with hysteresis.
// ----------------------------------------------------------------------------
// Takes one temperature request per cycle while the pipeline has a free
// slot, and returns one duty result per request, in order. The pipeline
// is: input register, divide by 1000 (one multiply by a reciprocal),
// hysteresis compare and priority pick (updates the active bits), speed
// times period/100 (second multiply), result register. Each stage holds
// while the one after it is full and stalled, so ready stays high whenever
// the pipeline has a free slot.
// Configuration writes take effect on the next edge and must be made while
// no request is in flight; after a period write, period/100 is recomputed
// into its own register from the period register.
module fan_curve_hysteresis_duty_core #(
  parameter int POINTS = 8   // curve points in use, 2..8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fchd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fchd_pkg::CFG_DATA_W-1:0]    cfg_data,
  fchd_temp_if.sink                          sample,
  fchd_duty_if.source                        result
);

  // configuration registers
  fchd_pkg::curve_t  on_thresholds;
  fchd_pkg::curve_t  off_thresholds;
  fchd_pkg::curve_t  speed_table;
  fchd_pkg::period_t pwm_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_thresholds  <= '0;
      off_thresholds <= '0;
      speed_table    <= '0;
      pwm_period     <= '0;
    end else if (cfg_we) begin
      unique case (fchd_pkg::reg_index_t'(cfg_index))
        fchd_pkg::REG_ON_THRESHOLDS:  on_thresholds  <= cfg_data;
        fchd_pkg::REG_OFF_THRESHOLDS: off_thresholds <= cfg_data;
        fchd_pkg::REG_SPEED_TABLE:    speed_table    <= cfg_data;
        fchd_pkg::REG_PWM_PERIOD:     pwm_period     <= cfg_data[fchd_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids: 0 input reg, 1 degrees, 2 speed/level, 3 result
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;
  logic take, adv01, adv12, adv23;

  // ready ripples back from the result side
  assign rdy3  = !v3 || result.ready;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;
  assign rdy0  = !v0 || rdy1;

  assign take  = sample.valid && rdy0;
  assign adv01 = v0 && rdy1;
  assign adv12 = v1 && rdy2;   // active bits update here, in request order
  assign adv23 = v2 && rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (take) begin
        v0 <= 1'b1;
      end else if (adv01) begin
        v0 <= 1'b0;
      end
      if (adv01) begin
        v1 <= 1'b1;
      end else if (adv12) begin
        v1 <= 1'b0;
      end
      if (adv12) begin
        v2 <= 1'b1;
      end else if (adv23) begin
        v2 <= 1'b0;
      end
      if (adv23) begin
        v3 <= 1'b1;
      end else if (result.ready) begin
        v3 <= 1'b0;
      end
    end
  end

  // input register
  fchd_pkg::temp_t temp_milli;

  always_ff @(posedge clk) begin
    if (take) begin
      temp_milli <= sample.temp_milli;
    end
  end

  fchd_pkg::deg_t   deg;
  fchd_pkg::speed_t speed;
  fchd_pkg::level_t level;

  fchd_temp_scale u_scale (
    .clk        (clk),
    .load       (adv01),
    .temp_milli (temp_milli),
    .deg        (deg)
  );

  fchd_curve #(
    .POINTS (POINTS)
  ) u_curve (
    .clk            (clk),
    .rst            (rst),
    .load           (adv12),
    .deg            (deg),
    .on_thresholds  (on_thresholds),
    .off_thresholds (off_thresholds),
    .speed_table    (speed_table),
    .speed          (speed),
    .level          (level)
  );

  fchd_duty u_duty (
    .clk        (clk),
    .load       (adv23),
    .pwm_period (pwm_period),
    .speed      (speed),
    .level_in   (level),
    .duty       (result.duty),
    .level      (result.level)
  );

  assign sample.ready = rdy0;
  assign result.valid = v3;

endmodule
